>>> rtl/swhsr_pkg.sv
package swhsr_pkg;

	// Frame layout: humidity hi/lo, temperature hi/lo, checksum
	localparam int FRAME_BITS  = 40;
	localparam int BIT_INDEX_W = $clog2(FRAME_BITS + 1);

	localparam int START_W   = 20;
	localparam int WAIT_W    = 10;
	localparam int TIMEOUT_W = 16;
	localparam int CFG_DATA_W = START_W;
	localparam int CFG_INDEX_W = 2;

	localparam logic [START_W-1:0]   START_LOW_RST = START_W'(18000);
	localparam logic [WAIT_W-1:0]    RESP_WAIT_RST = WAIT_W'(30);
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = TIMEOUT_W'(1000);
	localparam logic                 SENSOR_RST    = 1'b1;

	localparam logic [CFG_INDEX_W-1:0] REG_START_LOW = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RESP_WAIT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT   = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SENSOR    = 2'd3;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_TIMEOUT  = 2'd1;
	localparam logic [1:0] STATUS_CHECKSUM = 2'd2;

	localparam logic SENSOR_DHT22 = 1'b1;

	typedef enum logic [6:0] {
		PH_IDLE      = 7'b0000001,
		PH_START     = 7'b0000010,
		PH_WAIT      = 7'b0000100,
		PH_ACK_LOW   = 7'b0001000,
		PH_ACK_HIGH  = 7'b0010000,
		PH_DATA_LOW  = 7'b0100000,
		PH_DATA_HIGH = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic line_level;
		logic start_request;
	} in_word_t;

	typedef struct packed {
		logic               drive_low;
		logic               busy_res;
		logic               done_res;
		logic [1:0]         status;
		logic [15:0]        humidity;
		logic signed [15:0] temperature;
	} out_word_t;

	typedef struct packed {
		logic [START_W-1:0]   start_low_ticks;
		logic [WAIT_W-1:0]    response_wait_ticks;
		logic [TIMEOUT_W-1:0] timeout_ticks;
		logic                 sensor_type;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [15:0]        humidity;
		logic signed [15:0] temperature;
	} reading_t;

endpackage

>>> rtl/swhsr_decode.sv
module swhsr_decode
	import swhsr_pkg::*;
(
	input  logic [FRAME_BITS-1:0] frame,
	input  logic                  sensor_type,
	output reading_t              reading
);

	logic [7:0]  b0, b1, b2, b3, b4;
	logic [7:0]  sum;
	logic [15:0] mag;

	assign b0 = frame[39:32];
	assign b1 = frame[31:24];
	assign b2 = frame[23:16];
	assign b3 = frame[15:8];
	assign b4 = frame[7:0];

	assign sum = 8'(b0 + b1 + b2 + b3);
	assign mag = {1'b0, b2[6:0], b3};

	always_comb begin
		reading.status = (sum == b4) ? STATUS_OK : STATUS_CHECKSUM;
		if (sensor_type == SENSOR_DHT22) begin
			reading.humidity = {b0, b1};
			// sign-magnitude to two's complement; minus zero comes out as zero
			reading.temperature = b2[7] ? 16'(-mag) : mag;
		end else begin
			reading.humidity    = {8'd0, b0};
			reading.temperature = {8'd0, b2};
		end
	end

endmodule

>>> rtl/swhsr_fsm.sv
module swhsr_fsm
	import swhsr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_word_t  in_word,
	input  cfg_t      cfg,
	output out_word_t result
);

	phase_t                 phase_q, ph;
	logic [START_W-1:0]     interval_q, ic;
	logic [TIMEOUT_W-1:0]   pulse_q, pc;
	logic [TIMEOUT_W-1:0]   low_len_q, ll;
	logic [BIT_INDEX_W-1:0] bit_idx_q, bi;
	logic [FRAME_BITS-1:0]  frame_q, fb;
	logic [1:0]             status_q, st;
	logic [15:0]            hum_q, hum;
	logic signed [15:0]     temp_q, tmp;

	logic                  drive, done, want, data_bit;
	logic [START_W-1:0]    start_len;
	logic [FRAME_BITS-1:0] frame_full;
	reading_t              reading;

	// Bit decision and frame decode work from the registered state only
	assign data_bit   = pulse_q > low_len_q;
	assign frame_full = {frame_q[FRAME_BITS-2:0], data_bit};
	assign start_len  = (cfg.start_low_ticks == '0) ? START_W'(1) : cfg.start_low_ticks;

	swhsr_decode u_decode (
		.frame       (frame_full),
		.sensor_type (cfg.sensor_type),
		.reading     (reading)
	);

	always_comb begin
		ph    = phase_q;
		ic    = interval_q;
		pc    = pulse_q;
		ll    = low_len_q;
		bi    = bit_idx_q;
		fb    = frame_q;
		st    = status_q;
		hum   = hum_q;
		tmp   = temp_q;
		drive = 1'b0;
		done  = 1'b0;
		want  = 1'b0;

		if (ph == PH_IDLE && in_word.start_request) begin
			ph = PH_START;
			ic = '0;
			pc = '0;
			ll = '0;
			bi = '0;
			fb = '0;
		end

		if (ph == PH_START) begin
			if (ic < start_len) begin
				drive = 1'b1;
				ic    = ic + START_W'(1);
			end else begin
				ph = PH_WAIT;
				ic = '0;
			end
		end

		if (ph == PH_WAIT) begin
			if (ic < START_W'(cfg.response_wait_ticks)) begin
				ic = ic + START_W'(1);
			end else begin
				ph = PH_ACK_LOW;
				pc = '0;
			end
		end else if (ph == PH_ACK_LOW || ph == PH_ACK_HIGH ||
				ph == PH_DATA_LOW || ph == PH_DATA_HIGH) begin
			want = (ph == PH_ACK_HIGH || ph == PH_DATA_HIGH);
			if (in_word.line_level == want) begin
				if (pc >= cfg.timeout_ticks) begin
					st   = STATUS_TIMEOUT;
					hum  = '0;
					tmp  = '0;
					ph   = PH_IDLE;
					done = 1'b1;
				end else begin
					pc = pc + TIMEOUT_W'(1);
				end
			end else if (pc == '0) begin
				st   = STATUS_TIMEOUT;
				hum  = '0;
				tmp  = '0;
				ph   = PH_IDLE;
				done = 1'b1;
			end else begin
				pc = TIMEOUT_W'(1);
				case (phase_q)
					PH_ACK_LOW:  ph = PH_ACK_HIGH;
					PH_ACK_HIGH: ph = PH_DATA_LOW;
					PH_DATA_LOW: begin
						ll = pulse_q;
						ph = PH_DATA_HIGH;
					end
					PH_DATA_HIGH: begin
						fb = frame_full;
						bi = bi + BIT_INDEX_W'(1);
						if (bi >= BIT_INDEX_W'(FRAME_BITS)) begin
							st   = reading.status;
							hum  = reading.humidity;
							tmp  = reading.temperature;
							ph   = PH_IDLE;
							done = 1'b1;
						end else begin
							ph = PH_DATA_LOW;
						end
					end
					default: ph = PH_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			interval_q <= '0;
			pulse_q    <= '0;
			low_len_q  <= '0;
			bit_idx_q  <= '0;
			frame_q    <= '0;
			status_q   <= STATUS_OK;
			hum_q      <= '0;
			temp_q     <= '0;
		end else if (step) begin
			phase_q    <= ph;
			interval_q <= ic;
			pulse_q    <= pc;
			low_len_q  <= ll;
			bit_idx_q  <= bi;
			frame_q    <= fb;
			status_q   <= st;
			hum_q      <= hum;
			temp_q     <= tmp;
		end
	end

	always_comb begin
		result.drive_low   = drive;
		result.busy_res    = (ph != PH_IDLE);
		result.done_res    = done;
		result.status      = st;
		result.humidity    = hum;
		result.temperature = tmp;
	end

endmodule

>>> rtl/single_wire_humidity_sensor_reader.sv
// Single-wire humidity/temperature sensor reader (DHT11 / DHT22 style).
// Input channel: one word per sensor tick, carrying the sampled data line
// level and a start request. Every accepted word yields exactly one output
// word: the line drive for that tick, busy and done flags, and the status,
// humidity and temperature of the last finished read (held between reads).
// Latency: the result word is valid the cycle after its input word is
// accepted. Throughput: one word per cycle; the whole protocol step for a
// tick, frame decode included, sits between the state registers and the
// single output register.
// Stall: in_ready drops only while a result waits and out_ready is low; the
// word still held is then kept, and no tick is lost or repeated.
// Configuration: write enable, register index and data; writes land at once
// and should only be made while idle. Registers: start low ticks, response
// wait ticks, timeout ticks, sensor type (1 = DHT22).
// Reset: the sequencer returns to idle, the last reading reads as OK with
// zero humidity and temperature, and the registers take their defaults
// (18000, 30, 1000, DHT22).
module single_wire_humidity_sensor_reader
	import swhsr_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  in_word_t               in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output out_word_t              out_data,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	cfg_t      cfg_q;
	out_word_t result;
	out_word_t out_q;
	logic      out_valid_q;
	logic      step;

	// output register frees up when empty or being drained this cycle
	assign in_ready = !out_valid_q || out_ready;
	assign step     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_low_ticks     <= START_LOW_RST;
			cfg_q.response_wait_ticks <= RESP_WAIT_RST;
			cfg_q.timeout_ticks       <= TIMEOUT_RST;
			cfg_q.sensor_type         <= SENSOR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_LOW: cfg_q.start_low_ticks     <= cfg_wdata;
				REG_RESP_WAIT: cfg_q.response_wait_ticks <= cfg_wdata[WAIT_W-1:0];
				REG_TIMEOUT:   cfg_q.timeout_ticks       <= cfg_wdata[TIMEOUT_W-1:0];
				REG_SENSOR:    cfg_q.sensor_type         <= cfg_wdata[0];
				default:       cfg_q <= cfg_q;
			endcase
		end
	end

	// protocol sequencer: advances one tick per accepted word
	swhsr_fsm u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.in_word (in_data),
		.cfg     (cfg_q),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
